// ===== rtl/core/ssa_pkg.sv =====
package ssa_pkg;

    localparam int unsigned MAX_SAMPLES = 255;

    localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);
    localparam int PRESS_W    = 24;
    localparam int TEMP_W     = 16;
    localparam int AVG_W      = 24;
    localparam int TIME_W     = 32;
    localparam int STALE_W    = 16;
    localparam int PSUM_W     = PRESS_W + CNT_W;
    localparam int TSUM_W     = TEMP_W + CNT_W;
    localparam int DIV_W      = PSUM_W;
    localparam int DIV_STEP_W = $clog2(DIV_W);
    localparam int READY_BIT  = 3;

    localparam logic [CNT_W-1:0]   CNT_MAX     = CNT_W'(MAX_SAMPLES);
    localparam logic [STALE_W-1:0] STALE_RESET = STALE_W'(100);

    typedef enum logic [1:0] {
        OP_SAMPLE   = 2'd0,
        OP_RD_PRESS = 2'd1,
        OP_RD_TEMP  = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [TIME_W-1:0]  now_ms;
        logic [7:0]         status_byte;
        logic [PRESS_W-1:0] press_raw;
        logic [TEMP_W-1:0]  temp_raw;
    } t_in_item;

    typedef struct packed {
        logic capture;
        logic apply_sample;
        logic load_stale;
        logic load_held;
        logic div_start;
        logic div_commit;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic data_ready;
        logic stale;
        logic count_zero;
        logic div_done;
        logic out_room;
    } t_dp_stat;

endpackage

// ===== rtl/core/ssa_in_if.sv =====
interface ssa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] now_ms;
    logic [7:0]  status_byte;
    logic [7:0]  press_hi;
    logic [7:0]  press_mid;
    logic [7:0]  press_lo;
    logic [7:0]  temp_hi;
    logic [7:0]  temp_lo;

    modport source (
        output valid, operation, now_ms, status_byte,
        output press_hi, press_mid, press_lo, temp_hi, temp_lo,
        input  ready
    );

    modport sink (
        input  valid, operation, now_ms, status_byte,
        input  press_hi, press_mid, press_lo, temp_hi, temp_lo,
        output ready
    );
endinterface

// ===== rtl/core/ssa_out_if.sv =====
interface ssa_out_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic               held;
    logic signed [23:0] average;

    modport source (
        output valid, ok, held, average,
        input  ready
    );

    modport sink (
        input  valid, ok, held, average,
        output ready
    );
endinterface

// ===== rtl/core/sensor_sample_averager_core.sv =====
// Channel  Dir  Beat
// i_in     in   operation, now_ms, status_byte, press_hi/mid/lo, temp_hi/lo
// o_out    out  ok, held, average
// i_cfg    in   stale_limit_ms (write enable + data)
//
// Each beat passes IDLE, EVAL; a stale read or one with no new samples then
// EMIT; an averaging read DIVIDE (the 32-step shift-subtract divider), EMIT.
// One beat is in work at a time; a finished result waits in the output
// register while the next beat is accepted. A read result holds in EMIT while
// the output register is full and stalled. Reset is synchronous.
module sensor_sample_averager_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ssa_in_if.sink                        i_in,
    ssa_out_if.source                     o_out,
    input  logic                          i_cfg_wr_en,
    input  logic [ssa_pkg::STALE_W-1:0]   i_cfg_wr_data
);

    ssa_pkg::t_in_item  w_item;
    ssa_pkg::t_dp_cmd   w_cmd;
    ssa_pkg::t_dp_stat  w_stat;
    logic [ssa_pkg::AVG_W-1:0] w_avg;

    assign w_item.op          = ssa_pkg::t_op'(i_in.operation);
    assign w_item.now_ms      = i_in.now_ms;
    assign w_item.status_byte = i_in.status_byte;
    assign w_item.press_raw   = {i_in.press_hi, i_in.press_mid, i_in.press_lo};
    assign w_item.temp_raw    = {i_in.temp_hi, i_in.temp_lo};

    ssa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ssa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_out_ok      (o_out.ok),
        .o_out_held    (o_out.held),
        .o_out_avg     (w_avg)
    );

    assign o_out.average = w_avg;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input accepted again while a beat is in work");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!i_in.ready))
        else $error("result appeared without a beat in work");

    a_held_is_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ok |-> !o_out.held && (o_out.average == '0))
        else $error("stale result carries data");

    a_divide_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> !i_in.ready)
        else $error("input ready during division");

endmodule

// ===== rtl/core/ssa_div.sv =====
module ssa_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ssa_pkg::DIV_W-1:0]   i_dividend,
    input  logic [ssa_pkg::CNT_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [ssa_pkg::DIV_W-1:0]   o_quotient
);

    logic                             r_busy, n_busy;
    logic                             r_done, n_done;
    logic [ssa_pkg::DIV_STEP_W-1:0]   r_step, n_step;
    logic [ssa_pkg::CNT_W-1:0]        r_rem, n_rem;
    logic [ssa_pkg::DIV_W-1:0]        r_quo, n_quo;
    logic [ssa_pkg::CNT_W-1:0]        r_dvs, n_dvs;

    logic [ssa_pkg::CNT_W:0]          w_shift;
    logic [ssa_pkg::CNT_W:0]          w_diff;
    logic                             w_ge;

    assign w_shift = {r_rem, r_quo[ssa_pkg::DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = ~w_diff[ssa_pkg::CNT_W];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = ssa_pkg::DIV_STEP_W'(ssa_pkg::DIV_W - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem  = w_ge ? w_diff[ssa_pkg::CNT_W-1:0] : w_shift[ssa_pkg::CNT_W-1:0];
            n_quo  = {r_quo[ssa_pkg::DIV_W-2:0], w_ge};
            n_step = r_step - 1'b1;
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/core/ssa_dp.sv =====
module ssa_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ssa_pkg::t_in_item             i_item,
    input  logic                          i_cfg_wr_en,
    input  logic [ssa_pkg::STALE_W-1:0]   i_cfg_wr_data,
    input  ssa_pkg::t_dp_cmd              i_cmd,
    output ssa_pkg::t_dp_stat             o_stat,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_out_ok,
    output logic                          o_out_held,
    output logic [ssa_pkg::AVG_W-1:0]     o_out_avg
);

    ssa_pkg::t_in_item               r_item;
    logic [ssa_pkg::STALE_W-1:0]     r_limit;
    logic [ssa_pkg::PSUM_W-1:0]      r_psum, n_psum;
    logic [ssa_pkg::CNT_W-1:0]       r_pcnt, n_pcnt;
    logic [ssa_pkg::TSUM_W-1:0]      r_tsum, n_tsum;
    logic [ssa_pkg::CNT_W-1:0]       r_tcnt, n_tcnt;
    logic [ssa_pkg::AVG_W-1:0]       r_held_p, n_held_p;
    logic [ssa_pkg::TEMP_W-1:0]      r_held_t, n_held_t;
    logic [ssa_pkg::TIME_W-1:0]      r_last, n_last;
    logic                            r_neg;
    logic                            r_res_ok, n_res_ok;
    logic                            r_res_held, n_res_held;
    logic [ssa_pkg::AVG_W-1:0]       r_res_avg, n_res_avg;
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_ok;
    logic                            r_out_held;
    logic [ssa_pkg::AVG_W-1:0]       r_out_avg;

    logic                            w_is_press;
    logic [ssa_pkg::PSUM_W-1:0]      w_p_ext;
    logic [ssa_pkg::TSUM_W-1:0]      w_t_ext;
    logic [ssa_pkg::DIV_W-1:0]       w_sel_sum;
    logic [ssa_pkg::DIV_W-1:0]       w_abs;
    logic [ssa_pkg::AVG_W-1:0]       w_held_sel;
    logic [ssa_pkg::TIME_W-1:0]      w_age;
    logic                            w_div_done;
    logic [ssa_pkg::DIV_W-1:0]       w_quo;
    logic [ssa_pkg::AVG_W-1:0]       w_avg;

    assign w_is_press = (r_item.op == ssa_pkg::OP_RD_PRESS);
    assign w_p_ext = {{ssa_pkg::CNT_W{r_item.press_raw[ssa_pkg::PRESS_W-1]}}, r_item.press_raw};
    assign w_t_ext = {{ssa_pkg::CNT_W{r_item.temp_raw[ssa_pkg::TEMP_W-1]}}, r_item.temp_raw};

    assign w_sel_sum = w_is_press ? r_psum :
        {{(ssa_pkg::DIV_W - ssa_pkg::TSUM_W){r_tsum[ssa_pkg::TSUM_W-1]}}, r_tsum};
    assign w_abs = w_sel_sum[ssa_pkg::DIV_W-1] ? (~w_sel_sum + 1'b1) : w_sel_sum;

    assign w_held_sel = w_is_press ? r_held_p :
        {{(ssa_pkg::AVG_W - ssa_pkg::TEMP_W){r_held_t[ssa_pkg::TEMP_W-1]}}, r_held_t};

    assign w_age = r_item.now_ms - r_last;

    ssa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_abs),
        .i_divisor  (w_is_press ? r_pcnt : r_tcnt),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_avg = r_neg ? (~w_quo[ssa_pkg::AVG_W-1:0] + 1'b1) : w_quo[ssa_pkg::AVG_W-1:0];

    always_comb begin
        n_psum      = r_psum;
        n_pcnt      = r_pcnt;
        n_tsum      = r_tsum;
        n_tcnt      = r_tcnt;
        n_held_p    = r_held_p;
        n_held_t    = r_held_t;
        n_last      = r_last;
        n_res_ok    = r_res_ok;
        n_res_held  = r_res_held;
        n_res_avg   = r_res_avg;
        n_out_valid = r_out_valid;

        if (i_cmd.apply_sample) begin
            if (r_pcnt < ssa_pkg::CNT_MAX) begin
                n_psum = r_psum + w_p_ext;
                n_pcnt = r_pcnt + 1'b1;
            end
            if (r_tcnt < ssa_pkg::CNT_MAX) begin
                n_tsum = r_tsum + w_t_ext;
                n_tcnt = r_tcnt + 1'b1;
            end
            n_last = r_item.now_ms;
        end

        if (i_cmd.load_stale) begin
            n_res_ok   = 1'b0;
            n_res_held = 1'b0;
            n_res_avg  = '0;
        end

        if (i_cmd.load_held) begin
            n_res_ok   = 1'b1;
            n_res_held = 1'b1;
            n_res_avg  = w_held_sel;
        end

        if (i_cmd.div_commit) begin
            n_res_ok   = 1'b1;
            n_res_held = 1'b0;
            n_res_avg  = w_avg;
            if (w_is_press) begin
                n_held_p = w_avg;
                n_psum   = '0;
                n_pcnt   = '0;
            end else begin
                n_held_t = w_avg[ssa_pkg::TEMP_W-1:0];
                n_tsum   = '0;
                n_tcnt   = '0;
            end
        end

        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= ssa_pkg::STALE_RESET;
            r_psum      <= '0;
            r_pcnt      <= '0;
            r_tsum      <= '0;
            r_tcnt      <= '0;
            r_held_p    <= '0;
            r_held_t    <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            r_psum      <= n_psum;
            r_pcnt      <= n_pcnt;
            r_tsum      <= n_tsum;
            r_tcnt      <= n_tcnt;
            r_held_p    <= n_held_p;
            r_held_t    <= n_held_t;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.div_start) begin
            r_neg <= w_sel_sum[ssa_pkg::DIV_W-1];
        end
        r_res_ok   <= n_res_ok;
        r_res_held <= n_res_held;
        r_res_avg  <= n_res_avg;
        if (i_cmd.out_load) begin
            r_out_ok   <= r_res_ok;
            r_out_held <= r_res_held;
            r_out_avg  <= r_res_avg;
        end
    end

    assign o_stat.op         = r_item.op;
    assign o_stat.data_ready = r_item.status_byte[ssa_pkg::READY_BIT];
    assign o_stat.stale      = w_age > {{(ssa_pkg::TIME_W - ssa_pkg::STALE_W){1'b0}}, r_limit};
    assign o_stat.count_zero = w_is_press ? (r_pcnt == '0) : (r_tcnt == '0);
    assign o_stat.div_done   = w_div_done;
    assign o_stat.out_room   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_ok    = r_out_ok;
    assign o_out_held  = r_out_held;
    assign o_out_avg   = r_out_avg;

endmodule

// ===== rtl/core/ssa_ctrl.sv =====
module ssa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ssa_pkg::t_dp_stat  i_stat,
    output ssa_pkg::t_dp_cmd   o_cmd
);

    ssa_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ssa_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ssa_pkg::ST_EVAL;
                end
            end
            ssa_pkg::ST_EVAL: begin
                unique case (i_stat.op)
                    ssa_pkg::OP_SAMPLE: begin
                        o_cmd.apply_sample = i_stat.data_ready;
                        n_state            = ssa_pkg::ST_IDLE;
                    end
                    ssa_pkg::OP_RD_PRESS, ssa_pkg::OP_RD_TEMP: begin
                        priority if (i_stat.stale) begin
                            o_cmd.load_stale = 1'b1;
                            n_state          = ssa_pkg::ST_EMIT;
                        end else if (i_stat.count_zero) begin
                            o_cmd.load_held = 1'b1;
                            n_state         = ssa_pkg::ST_EMIT;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = ssa_pkg::ST_DIVIDE;
                        end
                    end
                    ssa_pkg::OP_NONE: begin
                        n_state = ssa_pkg::ST_IDLE;
                    end
                endcase
            end
            ssa_pkg::ST_DIVIDE: begin
                if (i_stat.div_done) begin
                    o_cmd.div_commit = 1'b1;
                    n_state          = ssa_pkg::ST_EMIT;
                end
            end
            ssa_pkg::ST_EMIT: begin
                if (i_stat.out_room) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ssa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ssa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== verif/ssa_average_checker.sv =====
module ssa_average_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [1:0]                         i_operation,
    input  logic [ssa_pkg::TIME_W-1:0]         i_now_ms,
    input  logic [7:0]                         i_status_byte,
    input  logic [7:0]                         i_press_hi,
    input  logic [7:0]                         i_press_mid,
    input  logic [7:0]                         i_press_lo,
    input  logic [7:0]                         i_temp_hi,
    input  logic [7:0]                         i_temp_lo,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic                               i_ok,
    input  logic                               i_held,
    input  logic signed [ssa_pkg::AVG_W-1:0]   i_average,
    input  logic                               i_cfg_wr_en,
    input  logic [ssa_pkg::STALE_W-1:0]        i_cfg_wr_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    typedef struct {
        logic                             ok;
        logic                             held;
        logic signed [ssa_pkg::AVG_W-1:0] average;
    } t_reading;

    t_reading                          expected_readings[$];
    int                                fail_count;

    logic [ssa_pkg::STALE_W-1:0]       stale_limit;
    logic signed [ssa_pkg::PSUM_W-1:0] acc_press;
    logic [ssa_pkg::CNT_W-1:0]         cnt_press;
    logic signed [ssa_pkg::TSUM_W-1:0] acc_temp;
    logic [ssa_pkg::CNT_W-1:0]         cnt_temp;
    logic signed [ssa_pkg::AVG_W-1:0]  held_press;
    logic signed [ssa_pkg::AVG_W-1:0]  held_temp;
    logic [ssa_pkg::TIME_W-1:0]        stamp_ms;

    assign o_fail_count = fail_count;

    task automatic clear_averages();
        stale_limit = ssa_pkg::STALE_RESET;
        acc_press   = '0;
        cnt_press   = '0;
        acc_temp    = '0;
        cnt_temp    = '0;
        held_press  = '0;
        held_temp   = '0;
        stamp_ms    = '0;
    endtask

    task automatic absorb_beat(
        input ssa_pkg::t_op                op,
        input logic [ssa_pkg::TIME_W-1:0]  now,
        input logic [7:0]                  status,
        input logic [ssa_pkg::PRESS_W-1:0] press_raw,
        input logic [ssa_pkg::TEMP_W-1:0]  temp_raw
    );
        logic [ssa_pkg::TIME_W-1:0] age;
        t_reading                   r;
        case (op)
            ssa_pkg::OP_SAMPLE: begin
                if (status[ssa_pkg::READY_BIT]) begin
                    if (cnt_press < ssa_pkg::CNT_MAX) begin
                        acc_press = acc_press + ssa_pkg::PSUM_W'($signed(press_raw));
                        cnt_press = cnt_press + 1'b1;
                    end
                    if (cnt_temp < ssa_pkg::CNT_MAX) begin
                        acc_temp = acc_temp + ssa_pkg::TSUM_W'($signed(temp_raw));
                        cnt_temp = cnt_temp + 1'b1;
                    end
                    stamp_ms = now;
                end
            end
            ssa_pkg::OP_RD_PRESS, ssa_pkg::OP_RD_TEMP: begin
                age = now - stamp_ms;
                if (age > ssa_pkg::TIME_W'(stale_limit)) begin
                    r = '{ok: 1'b0, held: 1'b0, average: '0};
                end else if (op == ssa_pkg::OP_RD_PRESS) begin
                    if (cnt_press == '0) begin
                        r = '{ok: 1'b1, held: 1'b1, average: held_press};
                    end else begin
                        held_press = ssa_pkg::AVG_W'(acc_press / $signed({1'b0, cnt_press}));
                        acc_press  = '0;
                        cnt_press  = '0;
                        r = '{ok: 1'b1, held: 1'b0, average: held_press};
                    end
                end else begin
                    if (cnt_temp == '0) begin
                        r = '{ok: 1'b1, held: 1'b1, average: held_temp};
                    end else begin
                        held_temp = ssa_pkg::AVG_W'(acc_temp / $signed({1'b0, cnt_temp}));
                        acc_temp  = '0;
                        cnt_temp  = '0;
                        r = '{ok: 1'b1, held: 1'b0, average: held_temp};
                    end
                end
                expected_readings.push_back(r);
            end
            default: begin
            end
        endcase
    endtask

    task automatic compare_reading();
        t_reading r;
        if (expected_readings.size() == 0) begin
            $display("%0t: unexpected result ok=%0b held=%0b average=%0d",
                     $time, i_ok, i_held, i_average);
            fail_count++;
        end else begin
            r = expected_readings.pop_front();
            if (i_ok !== r.ok) begin
                $display("%0t: ok expected %0b actual %0b", $time, r.ok, i_ok);
                fail_count++;
            end
            if (i_held !== r.held) begin
                $display("%0t: held expected %0b actual %0b", $time, r.held, i_held);
                fail_count++;
            end
            if (i_average !== r.average) begin
                $display("%0t: average expected %0d actual %0d",
                         $time, r.average, i_average);
                fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_averages();
            expected_readings.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_wr_en) begin
                stale_limit = i_cfg_wr_data;
            end
            if (i_out_valid && i_out_ready) begin
                compare_reading();
            end
            if (i_in_valid && i_in_ready) begin
                absorb_beat(ssa_pkg::t_op'(i_operation), i_now_ms, i_status_byte,
                            {i_press_hi, i_press_mid, i_press_lo},
                            {i_temp_hi, i_temp_lo});
            end
        end
        o_pending = expected_readings.size();
    end

endmodule

// ===== verif/tb_sensor_sample_averager_core.sv =====
module tb_sensor_sample_averager_core;

    localparam int DRAIN_CYCLES   = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_STALL     = 300;
    localparam int PHASE_ITEMS    = 170;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        cfg_wr_en;
    logic [ssa_pkg::STALE_W-1:0] cfg_wr_data;

    int                          src_idle_pct;
    int                          sink_idle_pct;
    int                          stall_left;
    bit                          long_stall_req;
    bit                          long_stall_taken;
    logic [ssa_pkg::TIME_W-1:0]  clock_ms;
    int                          fail_count;
    int                          pending_count;

    ssa_in_if  in_bus ();
    ssa_out_if out_bus ();

    sensor_sample_averager_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_bus),
        .o_out         (out_bus),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    ssa_average_checker u_reading_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_bus.valid),
        .i_in_ready    (in_bus.ready),
        .i_operation   (in_bus.operation),
        .i_now_ms      (in_bus.now_ms),
        .i_status_byte (in_bus.status_byte),
        .i_press_hi    (in_bus.press_hi),
        .i_press_mid   (in_bus.press_mid),
        .i_press_lo    (in_bus.press_lo),
        .i_temp_hi     (in_bus.temp_hi),
        .i_temp_lo     (in_bus.temp_lo),
        .i_out_valid   (out_bus.valid),
        .i_out_ready   (out_bus.ready),
        .i_ok          (out_bus.ok),
        .i_held        (out_bus.held),
        .i_average     (out_bus.average),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        out_bus.ready    = 1'b0;
        stall_left       = 0;
        long_stall_taken = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_stall_req && !long_stall_taken) begin
                long_stall_taken = 1'b1;
                stall_left       = LONG_STALL;
            end
            if (stall_left > 0) begin
                out_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                out_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("sensor_sample_averager_core: mismatch");
        $finish;
    end

    task automatic send_item(
        input ssa_pkg::t_op                op,
        input logic [7:0]                  status,
        input logic [ssa_pkg::PRESS_W-1:0] press,
        input logic [ssa_pkg::TEMP_W-1:0]  temp
    );
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.operation   <= op;
        in_bus.now_ms      <= clock_ms;
        in_bus.status_byte <= status;
        in_bus.press_hi    <= press[23:16];
        in_bus.press_mid   <= press[15:8];
        in_bus.press_lo    <= press[7:0];
        in_bus.temp_hi     <= temp[15:8];
        in_bus.temp_lo     <= temp[7:0];
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_read(input ssa_pkg::t_op op);
        send_item(op, 8'($urandom), ssa_pkg::PRESS_W'($urandom),
                  ssa_pkg::TEMP_W'($urandom));
    endtask

    task automatic release_input();
        in_bus.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain_readings();
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_stale_limit(input logic [ssa_pkg::STALE_W-1:0] limit);
        @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [ssa_pkg::PRESS_W-1:0] rand_press();
        case ($urandom_range(0, 7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return ssa_pkg::PRESS_W'($urandom_range(0, 15)) - 24'd8;
            default: return ssa_pkg::PRESS_W'($urandom);
        endcase
    endfunction

    function automatic logic [ssa_pkg::TEMP_W-1:0] rand_temp();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return ssa_pkg::TEMP_W'($urandom_range(0, 15)) - 16'd8;
            default: return ssa_pkg::TEMP_W'($urandom);
        endcase
    endfunction

    task automatic advance_clock();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
            end
            4, 5, 6, 7: clock_ms = clock_ms + $urandom_range(1, 40);
            8:          clock_ms = clock_ms + $urandom_range(41, 70000);
            default:    clock_ms = $urandom;
        endcase
    endtask

    task automatic run_random(input int n);
        int           counted;
        int           burst;
        ssa_pkg::t_op op;
        logic [7:0]   status;
        counted = 0;
        while (counted < n) begin
            if ($urandom_range(0, 4) != 0) begin
                burst = ($urandom_range(0, 39) == 0) ? $urandom_range(200, 260)
                                                     : $urandom_range(1, 8);
                repeat (burst) begin
                    advance_clock();
                    send_item(ssa_pkg::OP_SAMPLE, 8'($urandom) | 8'h08,
                              rand_press(), rand_temp());
                end
                counted += burst;
                advance_clock();
                case ($urandom_range(0, 3))
                    0: begin
                        send_read(ssa_pkg::OP_RD_PRESS);
                        counted += 1;
                    end
                    1: begin
                        send_read(ssa_pkg::OP_RD_TEMP);
                        counted += 1;
                    end
                    2: begin
                        send_read(ssa_pkg::OP_RD_PRESS);
                        send_read(ssa_pkg::OP_RD_TEMP);
                        counted += 2;
                    end
                    default: begin
                        send_read(ssa_pkg::OP_RD_TEMP);
                        send_read(ssa_pkg::OP_RD_PRESS);
                        counted += 2;
                    end
                endcase
            end else begin
                advance_clock();
                op     = ssa_pkg::t_op'($urandom_range(0, 3));
                status = 8'($urandom);
                send_item(op, status, ssa_pkg::PRESS_W'($urandom),
                          ssa_pkg::TEMP_W'($urandom));
                if (op != ssa_pkg::OP_NONE &&
                    !(op == ssa_pkg::OP_SAMPLE && !status[ssa_pkg::READY_BIT])) begin
                    counted++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        long_stall_req     = 1'b0;
        src_idle_pct       = 9;
        sink_idle_pct      = 75;
        clock_ms           = '0;
        in_bus.valid       = 1'b0;
        in_bus.operation   = ssa_pkg::OP_SAMPLE;
        in_bus.now_ms      = '0;
        in_bus.status_byte = '0;
        in_bus.press_hi    = '0;
        in_bus.press_mid   = '0;
        in_bus.press_lo    = '0;
        in_bus.temp_hi     = '0;
        in_bus.temp_lo     = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        clock_ms = 32'd0;
        send_read(ssa_pkg::OP_RD_PRESS);
        clock_ms = 32'd50;
        send_read(ssa_pkg::OP_RD_TEMP);
        clock_ms = 32'd101;
        send_read(ssa_pkg::OP_RD_PRESS);
        clock_ms = 32'd100;
        send_read(ssa_pkg::OP_RD_TEMP);
        clock_ms = 32'd200;
        send_item(ssa_pkg::OP_SAMPLE, 8'hF7, 24'h123456, 16'h1234);
        send_read(ssa_pkg::OP_RD_PRESS);
        send_item(ssa_pkg::OP_SAMPLE, 8'hFF, 24'h7FFFFF, 16'h7FFF);
        clock_ms = 32'd210;
        send_item(ssa_pkg::OP_SAMPLE, 8'h08, 24'h800000, 16'h8000);
        send_read(ssa_pkg::OP_RD_PRESS);
        send_read(ssa_pkg::OP_RD_TEMP);
        clock_ms = 32'd220;
        send_item(ssa_pkg::OP_SAMPLE, 8'h0C, 24'hFFFFFD, 16'hFFFD);
        send_item(ssa_pkg::OP_SAMPLE, 8'h08, 24'hFFFFFC, 16'hFFFC);
        send_read(ssa_pkg::OP_RD_PRESS);
        send_read(ssa_pkg::OP_RD_PRESS);
        send_read(ssa_pkg::OP_RD_TEMP);
        send_item(ssa_pkg::OP_NONE, 8'hFF, 24'hFFFFFF, 16'hFFFF);
        clock_ms = 32'hFFFFFFF0;
        send_item(ssa_pkg::OP_SAMPLE, 8'h08, 24'h000001, 16'h0001);
        clock_ms = 32'h00000010;
        send_read(ssa_pkg::OP_RD_PRESS);
        clock_ms = 32'hFFFFFFEF;
        send_read(ssa_pkg::OP_RD_TEMP);
        release_input();
        drain_readings();

        write_stale_limit(16'hFFFF);
        run_random(PHASE_ITEMS);
        clock_ms = clock_ms + 32'd5;
        send_item(ssa_pkg::OP_SAMPLE, 8'h08, 24'h800000, 16'h8000);
        send_read(ssa_pkg::OP_RD_PRESS);
        send_read(ssa_pkg::OP_RD_TEMP);
        repeat (255) send_item(ssa_pkg::OP_SAMPLE, 8'h08, 24'h800000, 16'h8000);
        repeat (10) send_item(ssa_pkg::OP_SAMPLE, 8'hF8, 24'h7FFFFF, 16'h7FFF);
        send_read(ssa_pkg::OP_RD_PRESS);
        send_read(ssa_pkg::OP_RD_TEMP);
        release_input();
        drain_readings();

        src_idle_pct  = 75;
        sink_idle_pct = 9;
        write_stale_limit(16'h0000);
        run_random(PHASE_ITEMS);
        release_input();
        drain_readings();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_stale_limit(ssa_pkg::STALE_W'($urandom_range(1, 65534)));
        run_random(100);
        long_stall_req = 1'b1;
        run_random(PHASE_ITEMS - 100);
        release_input();
        drain_readings();

        if (fail_count == 0 && pending_count == 0) begin
            $display("sensor_sample_averager_core: match");
        end else begin
            $display("sensor_sample_averager_core: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ssa_pkg.sv
rtl/core/ssa_in_if.sv
rtl/core/ssa_out_if.sv
rtl/core/ssa_div.sv
rtl/core/ssa_dp.sv
rtl/core/ssa_ctrl.sv
rtl/core/sensor_sample_averager_core.sv
verif/ssa_average_checker.sv
verif/tb_sensor_sample_averager_core.sv
